// ===== sv/als_pkg.sv =====
// ----------------------------------------------------------------------------
// als_pkg: shared types and constants for the addressable LED serializer
// Action and register codes, field widths and frame sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package als_pkg;

  // Chain geometry
  localparam int LED_COUNT    = 22;
  localparam int BITS_PER_LED = 24;

  // Field widths
  localparam int LED_INDEX_W     = 6;
  localparam int COLOUR_W        = 8;
  localparam int PIXEL_W         = 3 * COLOUR_W;
  localparam int RESET_PERIODS_W = 10;
  localparam int TICKS_W         = 8;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 10;

  // Frame sizing
  localparam int LED_SEL_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int DATA_PERIODS = LED_COUNT * BITS_PER_LED;
  localparam int MAX_FRAME   = (1 << RESET_PERIODS_W) - 1 + DATA_PERIODS;
  localparam int POS_W       = $clog2(MAX_FRAME + 1);

  // Period position split: 24 = 8 * 3, so drop three bits and divide by 3
  // with a reciprocal multiply (exact for group values below 2048).
  localparam int GROUP_W    = POS_W - 3;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_MUL_W = 10;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = GROUP_W + DIV3_MUL_W;
  localparam int LED_NUM_W  = PROD_W - DIV3_SHIFT;
  localparam int BIT_SEL_W  = 5;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_SET_PIXEL = 2'd1,
    ACT_SHOW      = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RESET_PERIODS = 2'd0,
    REG_PERIOD_TICKS  = 2'd1,
    REG_ZERO_HIGH     = 2'd2,
    REG_ONE_HIGH      = 2'd3
  } cfg_reg_t;

  localparam logic [RESET_PERIODS_W-1:0] RESET_PERIODS_RST = 10'd125;
  localparam logic [TICKS_W-1:0]         PERIOD_TICKS_RST  = 8'd3;
  localparam logic [TICKS_W-1:0]         ZERO_HIGH_RST     = 8'd1;
  localparam logic [TICKS_W-1:0]         ONE_HIGH_RST      = 8'd2;

endpackage

`default_nettype wire

// ===== sv/als_if.sv =====
// ----------------------------------------------------------------------------
// als_if: request channels of the addressable LED serializer
// Input request, result and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface als_in_if;
  import als_pkg::*;

  logic                   valid;
  logic                   ready;
  action_t                action;
  logic [LED_INDEX_W-1:0] led_index;
  logic [COLOUR_W-1:0]    red;
  logic [COLOUR_W-1:0]    green;
  logic [COLOUR_W-1:0]    blue;

  modport source (output valid, action, led_index, red, green, blue, input ready);
  modport sink   (input valid, action, led_index, red, green, blue, output ready);
endinterface

interface als_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;
  logic write_rejected;

  modport source (output valid, line_level, busy_res, frame_done, write_rejected,
                  input ready);
  modport sink   (input valid, line_level, busy_res, frame_done, write_rejected,
                  output ready);
  modport mon    (input valid, ready, line_level, busy_res, frame_done,
                  write_rejected);
endinterface

interface als_cfg_if;
  import als_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/addressable_led_serializer.sv =====
// ----------------------------------------------------------------------------
// addressable_led_serializer: one-wire driver for a chain of RGB LEDs
// Colour store, frame sequencer and line waveform, one request per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : requests (tick, set pixel, show frame, clear all and show).
//             Each tick request is one timer tick of the line waveform.
//   out_if  : one result per request: line level for that tick, busy flag,
//             end-of-frame flag and rejected-write flag.
//   cfg_if  : register writes (reset periods, period ticks, zero and one
//             high ticks); always ready; write only while no request is open, which the block itself does not enforce.
// Path: an accepted request is held in the request register, its result in the
//   result register. Throughput: one request per cycle while the receiver takes
//   results; the request register feeds a single pass of logic (period split,
//   store lookup, duty compare, counter update) into the result register.
// Reset: store reads as unwritten (all-low periods), no frame running,
//   registers at 125 / 3 / 1 / 2, both channel registers empty.
// Receiver stall: the result register holds, the request register holds its
//   request, and in_if.ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module addressable_led_serializer (
  input  wire        clk,
  input  wire        rst_n,
  als_in_if.sink     in_if,
  als_out_if.source  out_if,
  als_cfg_if.sink    cfg_if
);
  import als_pkg::*;

  // Configuration registers
  logic [RESET_PERIODS_W-1:0] reset_periods_r;
  logic [TICKS_W-1:0]         period_ticks_r;
  logic [TICKS_W-1:0]         zero_high_r;
  logic [TICKS_W-1:0]         one_high_r;

  // Request register
  logic                   s1_valid_r;
  action_t                s1_action_r;
  logic [LED_INDEX_W-1:0] s1_index_r;
  logic [COLOUR_W-1:0]    s1_red_r;
  logic [COLOUR_W-1:0]    s1_green_r;
  logic [COLOUR_W-1:0]    s1_blue_r;

  // Colour store
  logic [PIXEL_W-1:0] colour_r  [LED_COUNT];
  logic [LED_COUNT-1:0] written_r;

  // Frame state
  logic             sending_r, sending_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TICKS_W-1:0] tick_r, tick_nxt;

  // Result register
  logic out_valid_r;
  logic out_level_r, out_level_nxt;
  logic out_busy_r, out_busy_nxt;
  logic out_done_r, out_done_nxt;
  logic out_rej_r, out_rej_nxt;

  logic process;
  logic idx_ok;
  logic [LED_SEL_W-1:0] idx_sel;

  // Period decode
  logic               in_reset;
  logic [POS_W-1:0]   q;
  logic [GROUP_W-1:0] grp;
  logic [PROD_W-1:0]  prod;
  logic [LED_NUM_W-1:0] led_num;
  logic [GROUP_W-1:0] led_x3;
  logic [1:0]         grp_rem;
  logic [BIT_SEL_W-1:0] bit_sel;
  logic [BIT_SEL_W-1:0] bit_pos;
  logic               led_ok;
  logic [LED_SEL_W-1:0] led_sel;
  logic [PIXEL_W-1:0] pixel;
  logic               bit_val;
  logic [TICKS_W-1:0] high_ticks;

  logic [TICKS_W:0]   tick_inc;
  logic [TICKS_W:0]   period_len;
  logic               period_end;
  logic [POS_W:0]     pos_inc;
  logic [POS_W:0]     frame_len;

  assign process      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || process;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid          = out_valid_r;
  assign out_if.line_level     = out_level_r;
  assign out_if.busy_res       = out_busy_r;
  assign out_if.frame_done     = out_done_r;
  assign out_if.write_rejected = out_rej_r;

  assign idx_ok  = {1'b0, s1_index_r} < (LED_INDEX_W + 1)'(LED_COUNT);
  assign idx_sel = s1_index_r[LED_SEL_W-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_periods_r <= RESET_PERIODS_RST;
      period_ticks_r  <= PERIOD_TICKS_RST;
      zero_high_r     <= ZERO_HIGH_RST;
      one_high_r      <= ONE_HIGH_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_RESET_PERIODS: reset_periods_r <= cfg_if.data[RESET_PERIODS_W-1:0];
        REG_PERIOD_TICKS:  period_ticks_r  <= cfg_if.data[TICKS_W-1:0];
        REG_ZERO_HIGH:     zero_high_r     <= cfg_if.data[TICKS_W-1:0];
        REG_ONE_HIGH:      one_high_r      <= cfg_if.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_action_r <= in_if.action;
      s1_index_r  <= in_if.led_index;
      s1_red_r    <= in_if.red;
      s1_green_r  <= in_if.green;
      s1_blue_r   <= in_if.blue;
    end
  end

  // Colour store: clear wipes every entry, set pixel writes one
  always_ff @(posedge clk) begin
    if (process && s1_action_r == ACT_CLEAR) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        colour_r[i] <= '0;
      end
    end else if (process && s1_action_r == ACT_SET_PIXEL && idx_ok) begin
      colour_r[idx_sel] <= {s1_green_r, s1_red_r, s1_blue_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (process && s1_action_r == ACT_CLEAR) begin
      written_r <= '1;
    end else if (process && s1_action_r == ACT_SET_PIXEL && idx_ok) begin
      written_r[idx_sel] <= 1'b1;
    end
  end

  // Split the period position into LED number and bit within the LED
  always_comb begin
    in_reset = pos_r < POS_W'(reset_periods_r);
    q        = pos_r - POS_W'(reset_periods_r);
    grp      = q[POS_W-1:3];
    prod     = PROD_W'(grp) * PROD_W'(DIV3_MUL);
    led_num  = prod[PROD_W-1:DIV3_SHIFT];
    led_x3   = GROUP_W'({led_num, 1'b0}) + GROUP_W'(led_num);
    grp_rem  = 2'(grp - led_x3);
    bit_sel  = {grp_rem, q[2:0]};
    bit_pos  = BIT_SEL_W'(PIXEL_W - 1) - bit_sel;
    led_ok   = led_num < LED_NUM_W'(LED_COUNT);
    led_sel  = led_num[LED_SEL_W-1:0];
    pixel    = colour_r[led_sel];
    bit_val  = pixel[bit_pos];
    if (in_reset || !led_ok || !written_r[led_sel]) begin
      high_ticks = '0;
    end else begin
      high_ticks = bit_val ? one_high_r : zero_high_r;
    end
  end

  assign tick_inc   = {1'b0, tick_r} + (TICKS_W + 1)'(1);
  assign period_len = (period_ticks_r == '0) ? (TICKS_W + 1)'(1)
                                             : {1'b0, period_ticks_r};
  assign period_end = tick_inc >= period_len;
  assign pos_inc    = {1'b0, pos_r} + (POS_W + 1)'(1);
  assign frame_len  = (POS_W + 1)'(reset_periods_r) + (POS_W + 1)'(DATA_PERIODS);

  // Request processing: frame state update and result
  always_comb begin
    sending_nxt   = sending_r;
    pos_nxt       = pos_r;
    tick_nxt      = tick_r;
    out_level_nxt = 1'b0;
    out_busy_nxt  = 1'b0;
    out_done_nxt  = 1'b0;
    out_rej_nxt   = 1'b0;
    if (process) begin
      unique case (s1_action_r)
        ACT_TICK: begin
          if (sending_r) begin
            out_busy_nxt  = 1'b1;
            out_level_nxt = tick_r < high_ticks;
            tick_nxt      = tick_inc[TICKS_W-1:0];
            if (period_end) begin
              tick_nxt = '0;
              pos_nxt  = pos_inc[POS_W-1:0];
              if (pos_inc >= frame_len) begin
                sending_nxt  = 1'b0;
                pos_nxt      = '0;
                out_done_nxt = 1'b1;
              end
            end
          end
        end
        ACT_SET_PIXEL: begin
          out_rej_nxt  = !idx_ok;
          out_busy_nxt = sending_r;
        end
        ACT_SHOW, ACT_CLEAR: begin
          // start a frame unless one is running
          if (!sending_r) begin
            sending_nxt = 1'b1;
            pos_nxt     = '0;
            tick_nxt    = '0;
          end
          out_busy_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      pos_r     <= '0;
      tick_r    <= '0;
    end else begin
      sending_r <= sending_nxt;
      pos_r     <= pos_nxt;
      tick_r    <= tick_nxt;
    end
  end

  // Result register: load on process, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_level_r <= out_level_nxt;
      out_busy_r  <= out_busy_nxt;
      out_done_r  <= out_done_nxt;
      out_rej_r   <= out_rej_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/als_checker.sv =====
// ----------------------------------------------------------------------------
// als_checker: result channel checks for the addressable LED serializer
// Checks result flag combinations, stalled-result hold and empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module als_checker (
  input wire clk,
  input wire rst_n,
  input wire out_valid,
  input wire out_ready,
  input wire line_level,
  input wire busy_res,
  input wire frame_done,
  input wire write_rejected
);

  // End of frame only comes from a tick of a running frame
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> busy_res)
    else $error("frame_done without busy_res");

  // The line is driven only by a tick inside a frame
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_level |-> busy_res && !write_rejected)
    else $error("line high outside a frame tick");

  // A rejected write is never a tick result
  a_rej_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && write_rejected |-> !frame_done)
    else $error("rejected write carries frame_done");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_level)
      && $stable(busy_res) && $stable(frame_done)
      && $stable(write_rejected))
    else $error("stalled result changed");

endmodule

bind addressable_led_serializer als_checker u_als_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .line_level     (out_if.line_level),
  .busy_res       (out_if.busy_res),
  .frame_done     (out_if.frame_done),
  .write_rejected (out_if.write_rejected)
);

`default_nettype wire
